// File: sv/miller_rabin_prime_test_64_top_defines.svh
// Assertion macros for the prime tester.
// Used by miller_rabin_prime_test_64_top; no other dependencies.
`ifndef MILLER_RABIN_PRIME_TEST_64_TOP_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_64_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MRP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrp assertion failed");

// next-cycle implication
`define MRP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrp assertion failed");

`endif

// File: sv/mrp_pkg.sv
// Package for the 64-bit prime tester: sequencer states, witness table, constants.
// No dependencies.
package mrp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,    // waiting for a beat
		ST_SIEVE,   // small-prime remainders, one divisor after another
		ST_SETUP,   // pick witness set, split p-1
		ST_SPLIT,   // strip factors of two from d
		ST_WRED,    // reduce witness mod p
		ST_PSQ,     // exponentiation: multiply step (acc*base) if bit set
		ST_PBASE,   // exponentiation: square base
		ST_CHECK,   // x == 1 or p-1 after the power
		ST_SQR,     // repeated squaring
		ST_SQCHK,   // test squared value
		ST_MULRUN,  // shared modular multiplier busy
		ST_DONE     // result held for output
	} state_t;

	localparam logic [31:0] SMALL_PRIME_MASK = 32'h208A28AC;
	localparam logic [63:0] LIM_323 = 64'd323;
	localparam logic [63:0] LIM_1 = 64'd5329;
	localparam logic [63:0] LIM_2 = 64'd9080191;
	localparam logic [63:0] LIM_3 = 64'd4759123141;
	localparam logic [63:0] LIM_4 = 64'd1122004669633;

	// witness table: sets laid out back to back
	function automatic logic [30:0] witness(input logic [4:0] idx);
		case (idx)
			5'd0:    witness = 31'd377687;
			5'd1:    witness = 31'd31;
			5'd2:    witness = 31'd73;
			5'd3:    witness = 31'd2;
			5'd4:    witness = 31'd7;
			5'd5:    witness = 31'd61;
			5'd6:    witness = 31'd2;
			5'd7:    witness = 31'd13;
			5'd8:    witness = 31'd23;
			5'd9:    witness = 31'd1662803;
			5'd10:   witness = 31'd2;
			5'd11:   witness = 31'd325;
			5'd12:   witness = 31'd9375;
			5'd13:   witness = 31'd28178;
			5'd14:   witness = 31'd450775;
			5'd15:   witness = 31'd9780504;
			5'd16:   witness = 31'd1795265022;
			default: witness = 31'd0;
		endcase
	endfunction

	// small divisors for the sieve
	function automatic logic [4:0] sieve_div(input logic [2:0] idx);
		case (idx)
			3'd0:    sieve_div = 5'd2;
			3'd1:    sieve_div = 5'd3;
			3'd2:    sieve_div = 5'd5;
			3'd3:    sieve_div = 5'd7;
			3'd4:    sieve_div = 5'd11;
			3'd5:    sieve_div = 5'd13;
			3'd6:    sieve_div = 5'd17;
			default: sieve_div = 5'd1;
		endcase
	endfunction

endpackage

// File: sv/miller_rabin_prime_test_64_top.sv
// Deterministic 64-bit prime tester: sieve, then strong-probable-prime rounds.
// Values below 31 are looked up in a mask; the sieve then takes remainders by the small
// primes 2 to 17 in turn, stopping at the first that divides. Larger values run, per witness
// (up to 7), a restoring reduction and a series of modular products.
// Throughput: one candidate at a time; the next beat is taken the cycle after a result is accepted.
// Reset: asynchronous active-low arst_n returns the sequencer to idle, no output pending.
`include "miller_rabin_prime_test_64_top_defines.svh"
module miller_rabin_prime_test_64_top
	import mrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] candidate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_prime
);
	state_t state_q, state_d, ret_q;

	logic [63:0] p_q, d_q, e_q, base_q, x_q, pm1_q, rem_q, wred_q;
	logic [5:0]  sq_q, sqi_q;
	logic [4:0]  widx_q, wend_q;
	logic [2:0]  sidx_q;
	logic [6:0]  bit_q;
	logic        res_q;
	logic [4:0]  srem_q;
	logic        res_ld, res_d;

	// multiplier handshake
	logic        mul_start, mul_busy;
	logic [63:0] mul_a, mul_b, mul_res;
	logic        mul_sel_sq; // 1: operands x,x / base,base ; 0: x,base

	mrp_modmul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.m     (p_q),
		.busy  (mul_busy),
		.res   (mul_res)
	);

	// sieve remainder: one input bit per cycle would be slow, so fold by digit:
	// remainder of the 64-bit value by a 5-bit divisor, 4 bits a cycle
	logic [4:0] sdiv;
	logic [8:0] snext;
	assign sdiv = sieve_div(sidx_q);
	always_comb begin
		logic [8:0] t;
		t = {srem_q, p_q[63 - 4*bit_q[3:0] -: 4]};
		// t < 16*sdiv: up to four conditional subtracts of sdiv<<k
		if (t >= ({4'd0, sdiv} << 3)) t = t - ({4'd0, sdiv} << 3);
		if (t >= ({4'd0, sdiv} << 2)) t = t - ({4'd0, sdiv} << 2);
		if (t >= ({4'd0, sdiv} << 1)) t = t - ({4'd0, sdiv} << 1);
		if (t >= {4'd0, sdiv}) t = t - {4'd0, sdiv};
		snext = t;
	end

	// witness reduction: restoring division, one bit a cycle
	logic [64:0] wtry;
	assign wtry = {rem_q, wred_q[63]} - {1'b0, p_q};

	assign mul_a = mul_sel_sq ? (state_q == ST_PBASE ? base_q : x_q) : x_q;
	assign mul_b = (state_q == ST_PSQ) ? base_q : mul_a;

	// next state, verdict load and strobes
	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		mul_sel_sq = 1'b1;
		res_ld = 1'b0;
		res_d = 1'b0;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SIEVE;
			ST_SIEVE: begin
				if (p_q < 64'd31) begin
					res_ld = 1'b1;
					res_d = SMALL_PRIME_MASK[p_q[4:0]];
					state_d = ST_DONE;
				end else if (bit_q == 7'd15) begin
					if (snext == 9'd0) begin
						res_ld = 1'b1;
						res_d = 1'b0;
						state_d = ST_DONE;
					end else if (sidx_q == 3'd6) begin
						if (p_q < LIM_323) begin
							res_ld = 1'b1;
							res_d = 1'b1;
							state_d = ST_DONE;
						end else state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: state_d = ST_SPLIT;
			ST_SPLIT: if (d_q[0]) state_d = ST_WRED;
			ST_WRED: begin
				if (bit_q == 7'd64) begin
					if (rem_q == 64'd0) begin
						// witness divisible by p: passes
						if (widx_q == wend_q) begin
							res_ld = 1'b1;
							res_d = 1'b1;
							state_d = ST_DONE;
						end
					end else state_d = ST_PSQ;
				end
			end
			ST_PSQ: begin
				mul_sel_sq = 1'b0;
				if (e_q == 64'd0) state_d = ST_CHECK;
				else if (e_q[0]) begin
					mul_start = 1'b1;
					state_d = ST_MULRUN;
				end else state_d = ST_PBASE;
			end
			ST_PBASE: begin
				mul_start = 1'b1;
				state_d = ST_MULRUN;
			end
			ST_CHECK: begin
				if (x_q == 64'd1 || x_q == pm1_q || sq_q == 6'd0) begin
					if (!(x_q == 64'd1 || x_q == pm1_q)) begin
						res_ld = 1'b1;
						res_d = 1'b0;
						state_d = ST_DONE;
					end else if (widx_q == wend_q) begin
						res_ld = 1'b1;
						res_d = 1'b1;
						state_d = ST_DONE;
					end else state_d = ST_WRED;
				end else state_d = ST_SQR;
			end
			ST_SQR: begin
				mul_start = 1'b1;
				state_d = ST_MULRUN;
			end
			ST_SQCHK: begin
				if (x_q == 64'd1) begin
					res_ld = 1'b1;
					res_d = 1'b0;
					state_d = ST_DONE;
				end else if (x_q == pm1_q) begin
					if (widx_q == wend_q) begin
						res_ld = 1'b1;
						res_d = 1'b1;
						state_d = ST_DONE;
					end else state_d = ST_WRED;
				end else if (sqi_q + 6'd1 == sq_q) begin
					// all squarings used up without reaching p-1
					res_ld = 1'b1;
					res_d = 1'b0;
					state_d = ST_DONE;
				end else state_d = ST_SQR;
			end
			ST_MULRUN: if (!mul_busy) state_d = ret_q;
			ST_DONE:  if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_ld) res_q <= res_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				p_q <= candidate;
				sidx_q <= '0;
				bit_q <= '0;
				srem_q <= '0;
			end
			ST_SIEVE: begin
				bit_q <= (bit_q == 7'd15) ? 7'd0 : bit_q + 7'd1;
				srem_q <= (bit_q == 7'd15) ? 5'd0 : snext[4:0];
				if (bit_q == 7'd15) sidx_q <= sidx_q + 3'd1;
			end
			ST_SETUP: begin
				pm1_q <= p_q - 64'd1;
				d_q <= (p_q - 64'd1) >> 1;
				sq_q <= '0;
				if (p_q < LIM_1) begin widx_q <= 5'd0; wend_q <= 5'd0; end
				else if (p_q < LIM_2) begin widx_q <= 5'd1; wend_q <= 5'd2; end
				else if (p_q < LIM_3) begin widx_q <= 5'd3; wend_q <= 5'd5; end
				else if (p_q < LIM_4) begin widx_q <= 5'd6; wend_q <= 5'd9; end
				else begin widx_q <= 5'd10; wend_q <= 5'd16; end
				// first witness load happens on entry to reduction
				bit_q <= 7'd0;
				rem_q <= '0;
			end
			ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					sq_q <= sq_q + 6'd1;
				end else begin
					bit_q <= 7'd0;
					rem_q <= '0;
					wred_q <= {33'd0, witness(widx_q)};
				end
			end
			ST_WRED: begin
				if (bit_q == 7'd64) begin
					base_q <= rem_q;
					x_q <= 64'd1;
					e_q <= d_q;
					if (rem_q == 64'd0 && widx_q != wend_q) begin
						widx_q <= widx_q + 5'd1;
						wred_q <= {33'd0, witness(widx_q + 5'd1)};
						rem_q <= '0;
						bit_q <= 7'd0;
					end
				end else begin
					rem_q <= wtry[64] ? {rem_q[62:0], wred_q[63]} : wtry[63:0];
					wred_q <= wred_q << 1;
					bit_q <= bit_q + 7'd1;
				end
			end
			ST_PSQ: if (e_q != 64'd0 && e_q[0]) ret_q <= ST_PBASE;
			ST_PBASE: begin
				ret_q <= ST_PSQ;
				e_q <= e_q >> 1;
			end
			ST_CHECK: begin
				sqi_q <= '0;
				if ((x_q == 64'd1 || x_q == pm1_q) && widx_q != wend_q) begin
					widx_q <= widx_q + 5'd1;
					wred_q <= {33'd0, witness(widx_q + 5'd1)};
					rem_q <= '0;
					bit_q <= 7'd0;
				end
			end
			ST_SQR: ret_q <= ST_SQCHK;
			ST_SQCHK: begin
				sqi_q <= sqi_q + 6'd1;
				if (x_q == pm1_q && widx_q != wend_q) begin
					widx_q <= widx_q + 5'd1;
					wred_q <= {33'd0, witness(widx_q + 5'd1)};
					rem_q <= '0;
					bit_q <= 7'd0;
				end
			end
			ST_MULRUN: begin
				if (!mul_busy) begin
					if (ret_q == ST_PSQ) base_q <= mul_res;
					else x_q <= mul_res;
				end
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign is_prime = res_q;

	`MRP_ASSERT_IMP(a_mul_only_run, mul_busy, state_q == ST_MULRUN)
	`MRP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(is_prime))
	`MRP_ASSERT_IMP(a_wit_range, state_q == ST_PSQ, widx_q <= wend_q && wend_q <= 5'd16)
endmodule

// File: sv/mrp_modmul.sv
// Shared modular multiplier: (a*b) mod m by shift-and-add, one bit of b a cycle.
// Depends on nothing. Operands must already be below m.
module mrp_modmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] m,
	output logic        busy,
	output logic [63:0] res
);
	logic [63:0] acc_q, add_q, b_q, m_q;
	logic [6:0]  cnt_q;
	logic [64:0] sum_acc, sum_dbl;

	// doubled operands fit in 65 bits; one subtract keeps them below m
	assign sum_acc = {1'b0, acc_q} + {1'b0, add_q};
	assign sum_dbl = {add_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 7'd64;
		end else if (busy) begin
			if (cnt_q == 7'd1 || b_q == 64'd0) begin
				busy <= 1'b0;
			end
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			add_q <= a;
			b_q <= b;
			m_q <= m;
		end else if (busy && b_q != 64'd0) begin
			if (b_q[0]) begin
				acc_q <= (sum_acc >= {1'b0, m_q}) ? 64'(sum_acc - {1'b0, m_q})
				                                  : sum_acc[63:0];
			end
			add_q <= (sum_dbl >= {1'b0, m_q}) ? 64'(sum_dbl - {1'b0, m_q})
			                                  : sum_dbl[63:0];
			b_q <= b_q >> 1;
		end
	end

	assign res = acc_q;
endmodule
